// ----- hdl/k_smallest_selector_macros.svh -----
// Assertion shorthands, clocked on clk_i, off while rst_ni is low.
`ifndef K_SMALLEST_SELECTOR_MACROS_SVH
`define K_SMALLEST_SELECTOR_MACROS_SVH

// Same-cycle implication.
`define KSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("k_smallest_selector: check failed");

// Next-cycle implication.
`define KSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("k_smallest_selector: check failed");

`endif

// ----- hdl/kss_pkg.sv -----
package kss_pkg;

  localparam int unsigned K_MAX_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned KEEP_W    = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd4;

  typedef struct packed {
    logic ins;    // add while filling
    logic drop;   // replace the largest
    logic shift;  // move the row up by one (emit)
  } cmd_t;

  typedef struct packed {
    logic full;    // held count reached k or capacity
    logic top_gt;  // incoming word is below the largest held
    logic last;    // one word left
  } status_t;

endpackage

// ----- hdl/k_smallest_selector.sv -----
// channel  direction  handshake                 payload
// in       slave      in_valid_i / in_stall_o    element_value_i, set_end_i
// out      master     out_valid_o / out_stall_i  kept_value_o, run_end_o
// cfg      slave      cfg_we_i                   cfg_wdata_i (keep_count)
//
// One input word per cycle: a parallel compare across the sorted register row.
// A word with set_end_i is followed by n output words, one per cycle, n being the
// number held; the row shifts up by one per word taken. Input stalls meanwhile.
// Reset clears the held count; the row itself needs no clearing.
// A stalled output word holds until taken.
module k_smallest_selector #(
  parameter int unsigned K_MAX = kss_pkg::K_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kss_pkg::KEEP_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [kss_pkg::VAL_W-1:0]  element_value_i,
  input  logic                              set_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [kss_pkg::VAL_W-1:0]  kept_value_o,
  output logic                              run_end_o
);

  localparam int unsigned CW = $clog2(K_MAX + 1);

  kss_pkg::cmd_t    cmd;
  kss_pkg::status_t status;
  logic [CW-1:0]    k_eff;

  kss_ctrl #(
    .K_MAX (K_MAX),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .set_end_i   (set_end_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .k_eff_o     (k_eff)
  );

  kss_datapath #(
    .K_MAX (K_MAX),
    .CW    (CW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .k_eff_i         (k_eff),
    .element_value_i (element_value_i),
    .status_o        (status),
    .kept_value_o    (kept_value_o)
  );

  assign run_end_o = status.last;

endmodule

// ----- hdl/kss_datapath.sv -----
module kss_datapath #(
  parameter int unsigned K_MAX = kss_pkg::K_MAX_DEF,
  parameter int unsigned CW    = $clog2(K_MAX + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kss_pkg::cmd_t                       cmd_i,
  input  logic [CW-1:0]                       k_eff_i,
  input  logic signed [kss_pkg::VAL_W-1:0]    element_value_i,
  output kss_pkg::status_t                    status_o,
  output logic signed [kss_pkg::VAL_W-1:0]    kept_value_o
);

  // Held words sorted descending, cell 0 holds the largest.
  logic signed [kss_pkg::VAL_W-1:0] cell_q [K_MAX];
  logic signed [kss_pkg::VAL_W-1:0] cell_d [K_MAX];
  logic [CW-1:0] count_q, count_d;
  logic [K_MAX-1:0] cmp_w, gt_w, gtu_w;
  logic wr_en;

  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    localparam logic [CW-1:0] IDX  = CW'(g);
    localparam logic [CW-1:0] IDX1 = CW'(g + 1);
    logic signed [kss_pkg::VAL_W-1:0] up_w, dn_w;
    logic prev_gt, prev_gtu;

    assign cmp_w[g] = cell_q[g] > element_value_i;
    assign gt_w[g]  = cmp_w[g] && (count_q > IDX);

    if (g < K_MAX - 1) begin : g_up
      assign up_w     = cell_q[g+1];
      assign gtu_w[g] = cmp_w[g+1] && (count_q > IDX1);
    end else begin : g_top
      assign up_w     = cell_q[g];
      assign gtu_w[g] = 1'b0;
    end

    if (g > 0) begin : g_dn
      assign dn_w     = cell_q[g-1];
      assign prev_gt  = gt_w[g-1];
      assign prev_gtu = gtu_w[g-1];
    end else begin : g_first
      assign dn_w     = cell_q[g];
      assign prev_gt  = 1'b1;
      assign prev_gtu = 1'b1;
    end

    always_comb begin
      if (cmd_i.shift) begin
        cell_d[g] = up_w;
      end else if (cmd_i.drop) begin
        if (gtu_w[g]) cell_d[g] = up_w;
        else if (prev_gtu) cell_d[g] = element_value_i;
        else cell_d[g] = cell_q[g];
      end else begin
        if (gt_w[g]) cell_d[g] = cell_q[g];
        else if (prev_gt) cell_d[g] = element_value_i;
        else cell_d[g] = dn_w;
      end
    end
  end

  assign wr_en = cmd_i.ins || cmd_i.drop || cmd_i.shift;

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) count_d = count_q + CW'(1);
    else if (cmd_i.shift) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int i = 0; i < K_MAX; i++) cell_q[i] <= cell_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign status_o.full   = (count_q >= k_eff_i) || (count_q == CW'(K_MAX));
  assign status_o.top_gt = cmp_w[0];
  assign status_o.last   = count_q == CW'(1);
  assign kept_value_o    = cell_q[0];

endmodule

// ----- hdl/kss_ctrl.sv -----
module kss_ctrl #(
  parameter int unsigned K_MAX = kss_pkg::K_MAX_DEF,
  parameter int unsigned CW    = $clog2(K_MAX + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kss_pkg::KEEP_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        set_end_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  kss_pkg::status_t            status_i,
  output kss_pkg::cmd_t               cmd_o,
  output logic [CW-1:0]               k_eff_o
);

  typedef enum logic {
    ST_TAKE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic [kss_pkg::KEEP_W-1:0] keep_q;
  logic take;

  always_comb begin
    if (keep_q == '0) k_eff_o = CW'(1);
    else if (32'(keep_q) > 32'(K_MAX)) k_eff_o = CW'(K_MAX);
    else k_eff_o = CW'(keep_q);
  end

  assign take = (state_q == ST_TAKE) && in_valid_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_TAKE: begin
        cmd_o.ins  = take && !status_i.full;
        cmd_o.drop = take && status_i.full && status_i.top_gt;
        if (take && set_end_i) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.shift = !out_stall_i;
        if (!out_stall_i && status_i.last) state_d = ST_TAKE;
      end
      default: state_d = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TAKE;
      keep_q  <= kss_pkg::KEEP_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) keep_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o  = state_q != ST_TAKE;
  assign out_valid_o = state_q == ST_EMIT;

endmodule

// ----- hdl/kss_checker.sv -----
`include "k_smallest_selector_macros.svh"

module kss_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              set_end_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [kss_pkg::VAL_W-1:0]  kept_value_o,
  input logic                              run_end_o
);

  `KSS_ASSERT_NOW(a_no_take_while_emit, out_valid_o, in_stall_o)
  `KSS_ASSERT_NEXT(a_emit_after_end, in_valid_i && !in_stall_o && set_end_i, out_valid_o)
  `KSS_ASSERT_NEXT(a_idle_after_run, out_valid_o && !out_stall_i && run_end_o, !out_valid_o)
  `KSS_ASSERT_NEXT(a_hold_on_stall, out_valid_o && out_stall_i, out_valid_o && $stable(kept_value_o))

endmodule

bind k_smallest_selector kss_checker u_kss_checker (.*);

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned K        = kss_pkg::K_MAX_DEF;
  localparam int unsigned N_WORDS  = 420;
  localparam int unsigned SETTLE   = 4;
  localparam int unsigned LIMIT    = 200000;
  localparam int unsigned N_DIR    = 26;

  typedef struct packed {
    logic signed [kss_pkg::VAL_W-1:0] val;
    logic                             last;
  } kept_t;

  typedef struct packed {
    logic                             is_cfg;
    logic [kss_pkg::KEEP_W-1:0]       keep;
    logic signed [kss_pkg::VAL_W-1:0] v;
    logic                             e;
    logic                             typed;
    logic signed [kss_pkg::VAL_W-1:0] tval;
  } row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [kss_pkg::KEEP_W-1:0]       cfg_wdata_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic signed [kss_pkg::VAL_W-1:0] element_value_i = '0;
  logic                             set_end_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic signed [kss_pkg::VAL_W-1:0] kept_value_o;
  logic                             run_end_o;

  k_smallest_selector #(.K_MAX(K)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .set_end_i      (set_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kept_value_o   (kept_value_o),
    .run_end_o      (run_end_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [kss_pkg::VAL_W-1:0] held [K];
  int unsigned                      held_n = 0;
  logic [kss_pkg::KEEP_W-1:0]       keep_q = kss_pkg::KEEP_RESET;
  kept_t                            kept_q [$];

  int unsigned errors = 0;
  int unsigned n_in = 0;
  int unsigned n_sets = 0;
  int unsigned n_words = 0;
  int unsigned n_cfg = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  int unsigned stall_left = 0;
  row_t        dir_tab [N_DIR];

  function automatic void flag_err(input string msg);
    if (errors < 10) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endfunction

  function automatic void expect_word(input logic signed [kss_pkg::VAL_W-1:0] v,
                                      input logic last);
    kept_t w;
    w.val  = v;
    w.last = last;
    kept_q = {kept_q, w};
  endfunction

  function automatic void keep_insert(input logic signed [kss_pkg::VAL_W-1:0] v);
    int unsigned p;
    p = held_n;
    while (p > 0 && held[p-1] > v) begin
      held[p] = held[p-1];
      p--;
    end
    held[p] = v;
    held_n++;
  endfunction

  function automatic void take_word(input logic signed [kss_pkg::VAL_W-1:0] v,
                                    input logic e, input logic typed,
                                    input logic signed [kss_pkg::VAL_W-1:0] tval);
    int unsigned k;
    k = (keep_q == 0) ? 1 : (keep_q > K) ? K : keep_q;
    if (held_n < k && held_n < K) begin
      keep_insert(v);
    end else if (held_n > 0 && v < held[held_n-1]) begin
      held_n--;
      keep_insert(v);
    end
    if (e) begin
      if (typed) begin
        expect_word(tval, 1'b1);
      end else begin
        for (int i = int'(held_n) - 1; i >= 0; i--)
          expect_word(held[i], i == 0);
      end
      held_n = 0;
      n_sets++;
    end
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom % 8 == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_gap();
    if (calm || $urandom % 16 < 10) return 0;
    return pick_len();
  endfunction

  function automatic logic signed [kss_pkg::VAL_W-1:0] pick_value();
    case ($urandom % 8)
      0: return $urandom;
      1: begin
        case ($urandom % 6)
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh8000_0001;
          3: return 32'sh7fff_fffe;
          4: return 0;
          default: return -1;
        endcase
      end
      default: return $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic logic [kss_pkg::KEEP_W-1:0] pick_keep();
    case ($urandom % 4)
      0: return kss_pkg::KEEP_W'($urandom_range(0, 31));
      1: return kss_pkg::KEEP_W'($urandom_range(1, 4));
      2: return kss_pkg::KEEP_W'(K);
      default: return kss_pkg::KEEP_W'($urandom_range(5, 15));
    endcase
  endfunction

  task automatic offer_word(input logic signed [kss_pkg::VAL_W-1:0] v, input logic e,
                            input logic typed,
                            input logic signed [kss_pkg::VAL_W-1:0] tval);
    repeat (pick_gap()) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    element_value_i <= v;
    set_end_i       <= e;
    do @(posedge clk_i); while (in_stall_o);
    take_word(v, e, typed, tval);
    n_in++;
  endtask

  // only while idle: queue drained, then a settling wait before the write
  task automatic write_keep(input logic [kss_pkg::KEEP_W-1:0] k);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    keep_q = k;
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    kept_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_words++;
      if (kept_q.size() == 0) begin
        flag_err($sformatf("unexpected word %0d run_end %0b", kept_value_o, run_end_o));
      end else begin
        want = kept_q.pop_front();
        if (kept_value_o !== want.val || run_end_o !== want.last)
          flag_err($sformatf("word: exp %0d/%0b got %0d/%0b",
                             want.val, want.last, kept_value_o, run_end_o));
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom % 4 == 0) begin
      stall_left = pick_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // stretches without idling
  initial begin
    forever begin
      repeat ($urandom_range(100, 250)) @(posedge clk_i);
      calm = ($urandom % 3 == 0);
    end
  end

  // long receiver hold-off while the sender keeps going
  initial begin
    wait (n_in >= 90);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles", LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned set_no;
    int unsigned len;
    dir_tab = '{
      '{1'b0, 5'd0, 32'sd5,            1'b1, 1'b1, 32'sd5},
      '{1'b0, 5'd0, 32'sh8000_0000,    1'b1, 1'b1, 32'sh8000_0000},
      '{1'b0, 5'd0, 32'sh7fff_ffff,    1'b1, 1'b1, 32'sh7fff_ffff},
      '{1'b0, 5'd0, 32'sd7,            1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd3,            1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd9,            1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd3,            1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd1,            1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd7,            1'b1, 1'b0, 32'sd0},
      '{1'b1, 5'd0, 32'sd0,            1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd4,            1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, -32'sd2,           1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sh7fff_ffff,    1'b1, 1'b1, -32'sd2},
      '{1'b1, 5'd31, 32'sd0,           1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, -32'sd5,           1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd100,          1'b1, 1'b0, 32'sd0},
      '{1'b1, 5'd16, 32'sd0,           1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sh7fff_ffff,    1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sh8000_0000,    1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd0,            1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, -32'sd1,           1'b1, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd10,           1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd20,           1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd30,           1'b0, 1'b0, 32'sd0},
      '{1'b1, 5'd2, 32'sd0,            1'b0, 1'b0, 32'sd0},
      '{1'b0, 5'd0, 32'sd5,            1'b1, 1'b0, 32'sd0}
    };
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, duplicates, k of zero and above range, short set,
    // k lowered part way through a set
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].is_cfg)
        write_keep(dir_tab[i].keep);
      else
        offer_word(dir_tab[i].v, dir_tab[i].e, dir_tab[i].typed, dir_tab[i].tval);
    end

    set_no = 0;
    while (n_in < N_WORDS) begin
      if (set_no % 5 == 0) write_keep(pick_keep());
      case ($urandom % 8)
        0: len = $urandom_range(17, 24);
        1: len = 1;
        default: len = $urandom_range(2, 12);
      endcase
      for (int j = 0; j < len; j++)
        offer_word(pick_value(), j == len - 1, 1'b0, '0);
      set_no++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d words in %0d sets over %0d keep_count settings;", n_in, n_sets, n_cfg);
    $display("checked %0d emitted words, %0d mismatches.", n_words, errors);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
